// ===== rtl/core/mmr_pkg.sv =====
package mmr_pkg;

    localparam int CHANNELS    = 8;
    localparam int SAMPLE_BITS = 24;
    localparam int MASK_BITS   = 8;
    localparam int OUT_BITS    = SAMPLE_BITS + 1;

    // sum of the selected samples, count of selected channels
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(CHANNELS);
    localparam int CNT_BITS    = $clog2(MASK_BITS + 1);
    // numerator 2*S + n, and its magnitude form for the floor divide
    localparam int NUM_BITS    = SUM_BITS + 1;
    localparam int RECIP_BITS  = 32;
    localparam int PROD_BITS   = NUM_BITS + RECIP_BITS;

    // pipeline stages
    localparam int LANE_STAGE  = 0;
    localparam int SUM_STAGE   = 1;
    localparam int ABS_STAGE   = 2;
    localparam int MUL_STAGE   = 3;
    localparam int MEAN_STAGE  = 4;
    localparam int OUT_STAGE   = 5;
    localparam int STAGES      = 6;

    localparam int IN_DATA_BITS  = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((CHANNELS * OUT_BITS + 7) / 8) * 8;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [OUT_BITS-1:0]    result_t;

    typedef struct packed {
        logic [STAGES-1:0] load;
    } ctrl_t;

    // ceil(2^32 / (2n)); exact floor divide by 2n for magnitudes below 2^28
    function automatic logic [RECIP_BITS-1:0] recip_of(input logic [CNT_BITS-1:0] n);
        logic [RECIP_BITS-1:0] r;
        case (n)
            4'd1:    r = 32'd2147483648;
            4'd2:    r = 32'd1073741824;
            4'd3:    r = 32'd715827883;
            4'd4:    r = 32'd536870912;
            4'd5:    r = 32'd429496730;
            4'd6:    r = 32'd357913942;
            4'd7:    r = 32'd306783379;
            4'd8:    r = 32'd268435456;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/mmr_lane.sv =====
module mmr_lane
    import mmr_pkg::*;
(
    input  logic    clk,
    input  ctrl_t   ctrl,
    input  logic    sel,
    input  sample_t sample,
    input  result_t mean,
    output sample_t contrib,
    output result_t referenced
);

    sample_t samp_reg [OUT_STAGE];
    sample_t contrib_reg;
    result_t out_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[LANE_STAGE])
        begin
            samp_reg[LANE_STAGE] <= sample;
            contrib_reg          <= sel ? sample : '0;
        end
        // delay line matching the mean pipeline
        for (int k = LANE_STAGE + 1; k < OUT_STAGE; k++)
        begin
            if (ctrl.load[k])
            begin
                samp_reg[k] <= samp_reg[k-1];
            end
        end
        if (ctrl.load[OUT_STAGE])
        begin
            out_reg <= OUT_BITS'(samp_reg[OUT_STAGE-1]) - mean;
        end
    end

    assign contrib    = contrib_reg;
    assign referenced = out_reg;

endmodule

// ===== rtl/core/mmr_merge.sv =====
module mmr_merge
    import mmr_pkg::*;
(
    input  logic                clk,
    input  ctrl_t               ctrl,
    input  logic [CHANNELS-1:0] sel,
    input  sample_t             contrib [CHANNELS],
    output result_t             mean
);

    logic [CNT_BITS-1:0]        cnt0_reg;
    logic [CNT_BITS-1:0]        cnt1_reg;
    logic signed [SUM_BITS-1:0] sum1_reg;
    logic [NUM_BITS-1:0]        abs2_reg;
    logic                       neg2_reg;
    logic                       zero2_reg;
    logic [RECIP_BITS-1:0]      recip2_reg;
    logic [PROD_BITS-1:0]       prod3_reg;
    logic                       neg3_reg;
    logic                       zero3_reg;
    result_t                    mean4_reg;

    logic [CNT_BITS-1:0]        cnt_next;
    logic signed [SUM_BITS-1:0] sum_next;
    logic [NUM_BITS-1:0]        num;
    logic [NUM_BITS-1:0]        abs_next;
    logic                       neg;
    logic [NUM_BITS-1:0]        quot;
    result_t                    mean_next;

    always_comb
    begin
        cnt_next = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            cnt_next = cnt_next + CNT_BITS'(sel[i]);
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            sum_next = sum_next + SUM_BITS'(contrib[i]);
        end
    end

    // 2*S + n; a negative numerator is floored as -floor((-N + d - 1) / d)
    assign num      = {sum1_reg, 1'b0} + NUM_BITS'(cnt1_reg);
    assign neg      = num[NUM_BITS-1];
    assign abs_next = neg ? (~num + NUM_BITS'({cnt1_reg, 1'b0})) : num;

    assign quot = prod3_reg[PROD_BITS-1 -: NUM_BITS];

    always_comb
    begin
        if (zero3_reg)
        begin
            mean_next = '0;
        end
        else if (neg3_reg)
        begin
            mean_next = OUT_BITS'(-quot);
        end
        else
        begin
            mean_next = OUT_BITS'(quot);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[LANE_STAGE])
        begin
            cnt0_reg <= cnt_next;
        end
        if (ctrl.load[SUM_STAGE])
        begin
            sum1_reg <= sum_next;
            cnt1_reg <= cnt0_reg;
        end
        if (ctrl.load[ABS_STAGE])
        begin
            abs2_reg   <= abs_next;
            neg2_reg   <= neg;
            zero2_reg  <= (cnt1_reg == '0);
            recip2_reg <= recip_of(cnt1_reg);
        end
        if (ctrl.load[MUL_STAGE])
        begin
            prod3_reg <= PROD_BITS'(abs2_reg) * PROD_BITS'(recip2_reg);
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero2_reg;
        end
        if (ctrl.load[MEAN_STAGE])
        begin
            mean4_reg <= mean_next;
        end
    end

    assign mean = mean4_reg;

endmodule

// ===== rtl/core/multichannel_mean_rereference_core.sv =====
// Channel    Dir  Handshake              Payload
// s_*        in   s_tvalid / s_tready    s_tdata: one sample frame
// m_*        out  m_tvalid / m_tready    m_tdata: one re-referenced frame
// cfg_*      in   cfg_valid / cfg_ready  cfg_data: reference mask
//
// One frame per cycle sustained while m_tready is high. Six register stages (lane register, adder tree,
// numerator fold, reciprocal multiply, mean, per-lane subtract): a request taken
// into the lane register sets m_tvalid at the edge that loads the last stage.
// rst_n is asynchronous; it clears the stage valid bits and sets the mask
// to all channels. Each stage holds while its successor is full and stalled,
// so empty stages keep taking requests behind a stalled output.
module multichannel_mean_rereference_core
    import mmr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     s_tvalid,
    output logic                     s_tready,
    // sample_0..sample_7, 24 bits each, sample_0 in the lowest bits
    input  logic [IN_DATA_BITS-1:0]  s_tdata,

    output logic                     m_tvalid,
    input  logic                     m_tready,
    // referenced_0..referenced_7, 25 bits each, referenced_0 in the lowest bits
    output logic [OUT_DATA_BITS-1:0] m_tdata,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [MASK_BITS-1:0]     cfg_data
);

    logic [MASK_BITS-1:0] mask_reg;
    logic [STAGES-1:0]    valid_reg;
    logic [STAGES-1:0]    valid_next;
    logic [STAGES:0]      rdy;
    logic [STAGES-1:0]    vin;
    ctrl_t                ctrl;

    logic [CHANNELS-1:0]  sel;
    sample_t              sample   [CHANNELS];
    sample_t              contrib  [CHANNELS];
    result_t              referenced [CHANNELS];
    result_t              mean;

    // mask register, writable at any time the block is idle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mask_reg <= cfg_data;
        end
    end

    // elastic stage control: a stage loads when its input is valid and it is empty
    // or its successor takes its contents this cycle
    always_comb
    begin
        rdy[STAGES] = m_tready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        for (int k = 0; k < STAGES; k++)
        begin
            vin[k]           = (k == 0) ? s_tvalid : valid_reg[(k == 0) ? 0 : k - 1];
            ctrl.load[k]     = rdy[k] && vin[k];
            valid_next[k]    = rdy[k] ? vin[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[OUT_STAGE];

    // channels without a mask bit never join the mean
    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_sel
        if (i < MASK_BITS)
        begin : g_bit
            assign sel[i] = mask_reg[i];
        end
        else
        begin : g_none
            assign sel[i] = 1'b0;
        end
    end

    // lanes: per-channel select, delay and subtract
    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_lane
        assign sample[i] = s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];

        mmr_lane u_lane
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .sel        (sel[i]),
            .sample     (sample[i]),
            .mean       (mean),
            .contrib    (contrib[i]),
            .referenced (referenced[i])
        );

        assign m_tdata[i*OUT_BITS +: OUT_BITS] = referenced[i];
    end

    if (OUT_DATA_BITS > CHANNELS * OUT_BITS)
    begin : g_pad
        assign m_tdata[OUT_DATA_BITS-1:CHANNELS*OUT_BITS] = '0;
    end

    // merge: sum, count and rounded mean
    mmr_merge u_merge
    (
        .clk     (clk),
        .ctrl    (ctrl),
        .sel     (sel),
        .contrib (contrib),
        .mean    (mean)
    );

endmodule
